// File: rtl/rns_mixed_radix_compare_macros.svh
// assertion macros for the residue compare block
`ifndef RNS_MIXED_RADIX_COMPARE_MACROS_SVH
`define RNS_MIXED_RADIX_COMPARE_MACROS_SVH
`ifndef SYNTHESIS
`define RMC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("rmc check failed");
`define RMC_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("rmc check failed");
`else
`define RMC_ASSERT(lbl, clk, rst, prop)
`define RMC_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// File: rtl/rmc_pkg.sv
// shared constants and helpers for the residue compare block
package rmc_pkg;
   localparam int unsigned NUM_MODULI_DEF   = 3;
   localparam int unsigned MODULUS_BITS_DEF = 31;

   localparam logic [2:0] CSR_MODULUS_0  = 3'd0;
   localparam logic [2:0] CSR_MODULUS_1  = 3'd1;
   localparam logic [2:0] CSR_MODULUS_2  = 3'd2;
   localparam logic [2:0] CSR_INVERSE_01 = 3'd3;
   localparam logic [2:0] CSR_INVERSE_02 = 3'd4;
   localparam logic [2:0] CSR_INVERSE_12 = 3'd5;

   localparam logic [7:0] RST_MODULUS_0  = 8'd3;
   localparam logic [7:0] RST_MODULUS_1  = 8'd5;
   localparam logic [7:0] RST_MODULUS_2  = 8'd7;
   localparam logic [7:0] RST_INVERSE_01 = 8'd2;
   localparam logic [7:0] RST_INVERSE_02 = 8'd5;
   localparam logic [7:0] RST_INVERSE_12 = 8'd3;

   // cell stages in the conversion chain: two or four segments of one cell per bit
   function automatic int unsigned conv_latency(input int unsigned nm, input int unsigned mb);
      conv_latency = ((nm > 2) ? 4 : 2) * mb;
   endfunction
endpackage

// File: rtl/rmc_cell.sv
// one horner cell: doubles the accumulator and adds the operand on the top multiplier bit
module rmc_cell #(
   parameter int unsigned MB = rmc_pkg::MODULUS_BITS_DEF,
   parameter int unsigned PW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [MB-1:0] q_x,
   input  logic [MB-1:0] q_y,
   input  logic [MB-1:0] acc_x_in,
   input  logic [MB-1:0] op_x_in,
   input  logic [MB-1:0] bits_x_in,
   input  logic [MB-1:0] acc_y_in,
   input  logic [MB-1:0] op_y_in,
   input  logic [MB-1:0] bits_y_in,
   input  logic [PW-1:0] side_in,
   output logic [MB-1:0] acc_x_out,
   output logic [MB-1:0] op_x_out,
   output logic [MB-1:0] bits_x_out,
   output logic [MB-1:0] acc_y_out,
   output logic [MB-1:0] op_y_out,
   output logic [MB-1:0] bits_y_out,
   output logic [PW-1:0] side_out
);
   logic [MB-1:0] acc_x_ff, op_x_ff, bits_x_ff, acc_y_ff, op_y_ff, bits_y_ff;
   logic [MB-1:0] acc_x_in_nxt, acc_y_in_nxt;
   logic [PW-1:0] side_ff;

   // 2*acc + op stays below 3q, so one subtraction of q or 2q is enough
   function automatic logic [MB-1:0] step(input logic [MB-1:0] acc, input logic [MB-1:0] op,
                                          input logic bitv, input logic [MB-1:0] q);
      logic [MB+1:0] s, q1, q2, r;
      s  = {1'b0, acc, 1'b0} + {2'b00, (bitv ? op : {MB{1'b0}})};
      q1 = {2'b00, q};
      q2 = {1'b0, q, 1'b0};
      if (s >= q2) begin
         r = s - q2;
      end else if (s >= q1) begin
         r = s - q1;
      end else begin
         r = s;
      end
      step = r[MB-1:0];
   endfunction

   always_comb begin
      acc_x_in_nxt = step(acc_x_in, op_x_in, bits_x_in[MB-1], q_x);
      acc_y_in_nxt = step(acc_y_in, op_y_in, bits_y_in[MB-1], q_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_x_ff  <= acc_x_in_nxt;
         op_x_ff   <= op_x_in;
         bits_x_ff <= {bits_x_in[MB-2:0], 1'b0};
         acc_y_ff  <= acc_y_in_nxt;
         op_y_ff   <= op_y_in;
         bits_y_ff <= {bits_y_in[MB-2:0], 1'b0};
         side_ff   <= side_in;
      end
   end

   assign acc_x_out  = acc_x_ff;
   assign op_x_out   = op_x_ff;
   assign bits_x_out = bits_x_ff;
   assign acc_y_out  = acc_y_ff;
   assign op_y_out   = op_y_ff;
   assign bits_y_out = bits_y_ff;
   assign side_out   = side_ff;
endmodule

// File: rtl/rmc_seg.sv
// a row of horner cells, one per multiplier bit, forming two modular products or reductions (x and y)
module rmc_seg #(
   parameter int unsigned MB = rmc_pkg::MODULUS_BITS_DEF,
   parameter int unsigned PW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [MB-1:0] q_x,
   input  logic [MB-1:0] q_y,
   input  logic [MB-1:0] op_x,
   input  logic [MB-1:0] bits_x,
   input  logic [MB-1:0] op_y,
   input  logic [MB-1:0] bits_y,
   input  logic [PW-1:0] side_in,
   output logic [MB-1:0] acc_x_out,
   output logic [MB-1:0] acc_y_out,
   output logic [PW-1:0] side_out
);
   logic [MB-1:0] acc_x [0:MB];
   logic [MB-1:0] opx   [0:MB];
   logic [MB-1:0] bx    [0:MB];
   logic [MB-1:0] acc_y [0:MB];
   logic [MB-1:0] opy   [0:MB];
   logic [MB-1:0] by    [0:MB];
   logic [PW-1:0] sd    [0:MB];

   assign acc_x[0] = '0;
   assign opx[0]   = op_x;
   assign bx[0]    = bits_x;
   assign acc_y[0] = '0;
   assign opy[0]   = op_y;
   assign by[0]    = bits_y;
   assign sd[0]    = side_in;

   for (genvar i = 0; i < MB; i++) begin : g_cell
      rmc_cell #(.MB(MB), .PW(PW)) u_cell (
         .clock      (clock),
         .en         (en),
         .q_x        (q_x),
         .q_y        (q_y),
         .acc_x_in   (acc_x[i]),
         .op_x_in    (opx[i]),
         .bits_x_in  (bx[i]),
         .acc_y_in   (acc_y[i]),
         .op_y_in    (opy[i]),
         .bits_y_in  (by[i]),
         .side_in    (sd[i]),
         .acc_x_out  (acc_x[i+1]),
         .op_x_out   (opx[i+1]),
         .bits_x_out (bx[i+1]),
         .acc_y_out  (acc_y[i+1]),
         .op_y_out   (opy[i+1]),
         .bits_y_out (by[i+1]),
         .side_out   (sd[i+1])
      );
   end

   assign acc_x_out = acc_x[MB];
   assign acc_y_out = acc_y[MB];
   assign side_out  = sd[MB];
endmodule

// File: rtl/rmc_conv.sv
// mixed-radix conversion of one residue triple through chained segments
module rmc_conv #(
   parameter int unsigned NM = rmc_pkg::NUM_MODULI_DEF,
   parameter int unsigned MB = rmc_pkg::MODULUS_BITS_DEF
) (
   input  logic          clock,
   input  logic          en,
   input  logic [MB-1:0] res_0,
   input  logic [MB-1:0] res_1,
   input  logic [MB-1:0] res_2,
   input  logic [MB-1:0] mod_1,
   input  logic [MB-1:0] mod_2,
   input  logic [MB-1:0] inv_01,
   input  logic [MB-1:0] inv_02,
   input  logic [MB-1:0] inv_12,
   output logic [MB-1:0] dig_0,
   output logic [MB-1:0] dig_1,
   output logic [MB-1:0] dig_2
);
   localparam logic [MB-1:0] ONE = MB'(1);

   logic [MB-1:0]   red01, red02, diff1, diff2, d1, t2;
   logic [3*MB-1:0] side1;
   logic [MB-1:0]   side2;

   // both operands already below q
   function automatic logic [MB-1:0] sub_mod(input logic [MB-1:0] a, input logic [MB-1:0] b,
                                             input logic [MB-1:0] q);
      sub_mod = (a >= b) ? (a - b) : (a + (q - b));
   endfunction

   // d0 reduced into the two upper moduli
   rmc_seg #(.MB(MB), .PW(3*MB)) u_seg_red0 (
      .clock (clock), .en (en),
      .q_x (mod_1), .q_y (mod_2),
      .op_x (ONE), .bits_x (res_0), .op_y (ONE), .bits_y (res_0),
      .side_in ({res_2, res_1, res_0}),
      .acc_x_out (red01), .acc_y_out (red02), .side_out (side1)
   );

   assign diff1 = sub_mod(side1[2*MB-1:MB], red01, mod_1);
   assign diff2 = sub_mod(side1[3*MB-1:2*MB], red02, mod_2);

   rmc_seg #(.MB(MB), .PW(MB)) u_seg_mul0 (
      .clock (clock), .en (en),
      .q_x (mod_1), .q_y (mod_2),
      .op_x (diff1), .bits_x (inv_01), .op_y (diff2), .bits_y (inv_02),
      .side_in (side1[MB-1:0]),
      .acc_x_out (d1), .acc_y_out (t2), .side_out (side2)
   );

   if (NM > 2) begin : g_top
      logic [MB-1:0]   red12, u2;
      logic [3*MB-1:0] side3;
      logic [2*MB-1:0] side4;

      rmc_seg #(.MB(MB), .PW(3*MB)) u_seg_red1 (
         .clock (clock), .en (en),
         .q_x (mod_2), .q_y (mod_2),
         .op_x (ONE), .bits_x (d1), .op_y ('0), .bits_y ('0),
         .side_in ({t2, d1, side2}),
         .acc_x_out (red12), .acc_y_out (), .side_out (side3)
      );

      assign u2 = sub_mod(side3[3*MB-1:2*MB], red12, mod_2);

      rmc_seg #(.MB(MB), .PW(2*MB)) u_seg_mul1 (
         .clock (clock), .en (en),
         .q_x (mod_2), .q_y (mod_2),
         .op_x (u2), .bits_x (inv_12), .op_y ('0), .bits_y ('0),
         .side_in (side3[2*MB-1:0]),
         .acc_x_out (dig_2), .acc_y_out (), .side_out (side4)
      );

      assign dig_0 = side4[MB-1:0];
      assign dig_1 = side4[2*MB-1:MB];
   end else begin : g_two
      assign dig_0 = side2;
      assign dig_1 = d1;
      assign dig_2 = '0;
   end
endmodule

// File: rtl/rns_mixed_radix_compare.sv
// top level: residue pair to mixed-radix digits and a less-than flag
//
//  channel  dir  handshake           payload
//  req      in   req_tvalid/tready   tdata: a_res_0..2, b_res_0..2
//  rsp      out  rsp_tvalid/tready   tdata: a_digit_0..2, b_digit_0..2, a_less_b; tuser
//  csr      in   csr_we              csr_index, csr_wdata
//
// one item a cycle while the output register is not held; the row holds 2*MODULUS_BITS
// (two moduli) or 4*MODULUS_BITS (three moduli) cell stages plus one output register
// reset is synchronous, clears the stage and output valid bits and sets the csr registers to defaults
// the whole row advances when the output register is empty or being taken
`include "rns_mixed_radix_compare_macros.svh"
module rns_mixed_radix_compare #(
   parameter int unsigned NUM_MODULI   = rmc_pkg::NUM_MODULI_DEF,
   parameter int unsigned MODULUS_BITS = rmc_pkg::MODULUS_BITS_DEF,
   localparam int unsigned REQ_W = ((6 * MODULUS_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_W = ((6 * MODULUS_BITS + 8) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // a_res_0, a_res_1, a_res_2, b_res_0, b_res_1, b_res_2
   input  logic [REQ_W-1:0]        req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // a_digit_0..2, b_digit_0..2, a_less_b
   output logic [RSP_W-1:0]        rsp_tdata,
   // input_invalid
   output logic                    rsp_tuser,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [MODULUS_BITS-1:0] csr_wdata
);
   localparam int unsigned MB  = MODULUS_BITS;
   localparam int unsigned LAT = rmc_pkg::conv_latency(NUM_MODULI, MODULUS_BITS);

   logic [MB-1:0] mod_0_ff, mod_1_ff, mod_2_ff, inv_01_ff, inv_02_ff, inv_12_ff;
   logic [MB-1:0] a_res [0:2];
   logic [MB-1:0] b_res [0:2];
   logic [MB-1:0] a_dig [0:2];
   logic [MB-1:0] b_dig [0:2];
   logic [MB-1:0] mods  [0:2];
   logic          vld_ff [0:LAT-1];
   logic          inv_ff [0:LAT-1];
   logic          en, invalid_in, less;
   logic          rsp_tvalid_ff, rsp_tuser_ff;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_0_ff  <= MB'(rmc_pkg::RST_MODULUS_0);
         mod_1_ff  <= MB'(rmc_pkg::RST_MODULUS_1);
         mod_2_ff  <= MB'(rmc_pkg::RST_MODULUS_2);
         inv_01_ff <= MB'(rmc_pkg::RST_INVERSE_01);
         inv_02_ff <= MB'(rmc_pkg::RST_INVERSE_02);
         inv_12_ff <= MB'(rmc_pkg::RST_INVERSE_12);
      end else if (csr_we) begin
         case (csr_index)
            rmc_pkg::CSR_MODULUS_0:  mod_0_ff  <= csr_wdata;
            rmc_pkg::CSR_MODULUS_1:  mod_1_ff  <= csr_wdata;
            rmc_pkg::CSR_MODULUS_2:  mod_2_ff  <= csr_wdata;
            rmc_pkg::CSR_INVERSE_01: inv_01_ff <= csr_wdata;
            rmc_pkg::CSR_INVERSE_02: inv_02_ff <= csr_wdata;
            rmc_pkg::CSR_INVERSE_12: inv_12_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign mods[0] = mod_0_ff;
   assign mods[1] = mod_1_ff;
   assign mods[2] = mod_2_ff;

   always_comb begin
      invalid_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         a_res[k] = req_tdata[k*MB +: MB];
         b_res[k] = req_tdata[(k+3)*MB +: MB];
         if (k < NUM_MODULI) begin
            if (a_res[k] >= mods[k] || b_res[k] >= mods[k]) begin
               invalid_in = 1'b1;
            end
         end
      end
   end

   rmc_conv #(.NM(NUM_MODULI), .MB(MB)) u_conv_a (
      .clock (clock), .en (en),
      .res_0 (a_res[0]), .res_1 (a_res[1]), .res_2 (a_res[2]),
      .mod_1 (mod_1_ff), .mod_2 (mod_2_ff),
      .inv_01 (inv_01_ff), .inv_02 (inv_02_ff), .inv_12 (inv_12_ff),
      .dig_0 (a_dig[0]), .dig_1 (a_dig[1]), .dig_2 (a_dig[2])
   );

   rmc_conv #(.NM(NUM_MODULI), .MB(MB)) u_conv_b (
      .clock (clock), .en (en),
      .res_0 (b_res[0]), .res_1 (b_res[1]), .res_2 (b_res[2]),
      .mod_1 (mod_1_ff), .mod_2 (mod_2_ff),
      .inv_01 (inv_01_ff), .inv_02 (inv_02_ff), .inv_12 (inv_12_ff),
      .dig_0 (b_dig[0]), .dig_1 (b_dig[1]), .dig_2 (b_dig[2])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff[0] <= invalid_in;
         for (int i = 1; i < LAT; i++) begin
            inv_ff[i] <= inv_ff[i-1];
         end
      end
   end

   // lexicographic from the top digit
   assign less = (a_dig[2] < b_dig[2]) ||
                 (a_dig[2] == b_dig[2] && ((a_dig[1] < b_dig[1]) ||
                 (a_dig[1] == b_dig[1] && a_dig[0] < b_dig[0])));

   always_comb begin
      if (inv_ff[LAT-1]) begin
         rsp_tdata_in = '0;
      end else begin
         rsp_tdata_in = RSP_W'({less, b_dig[2], b_dig[1], b_dig[0],
                                a_dig[2], a_dig[1], a_dig[0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= inv_ff[LAT-1];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `RMC_ASSERT(a_invalid_zero, clock, reset, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
   `RMC_ASSERT(a_less_top, clock, reset, (rsp_tvalid && rsp_tdata[6*MB]) |-> (rsp_tdata[2*MB +: MB] <= rsp_tdata[5*MB +: MB]))
   `RMC_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_tvalid)
endmodule

// File: tb/tb.sv
// testbench for the residue pair mixed-radix compare block
`timescale 1ns / 1ps

module tb;
   localparam int unsigned MB     = rmc_pkg::MODULUS_BITS_DEF;
   localparam int unsigned REQ_W  = ((6 * MB + 7) / 8) * 8;
   localparam int unsigned RSP_W  = ((6 * MB + 8) / 8) * 8;
   localparam int unsigned SETTLE = rmc_pkg::conv_latency(rmc_pkg::NUM_MODULI_DEF, MB) + 16;

   typedef logic [MB-1:0] word_type;
   typedef word_type trio_type [3];
   typedef struct {
      word_type a_dig [3];
      word_type b_dig [3];
      bit       less;
      bit       invalid;
   } compare_result_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we;
   logic [2:0]       csr_index;
   logic [MB-1:0]    csr_wdata;

   // shadow of the block's registers
   longint unsigned modulus [3];
   longint unsigned inverse [3];   // 01, 02, 12

   compare_result_type pending_results [$];
   int  error_count;
   int  burst_left;
   bit  sender_gaps;
   bit  hold_request;
   int  hold_cycles;
   int  ready_mode;
   int  mode_left;

   rns_mixed_radix_compare i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb failed");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic longint unsigned reduce(longint unsigned x, longint unsigned q);
      return (q == 0) ? 0 : x % q;
   endfunction

   function automatic longint unsigned sub_mod(longint unsigned a, longint unsigned b,
                                               longint unsigned q);
      a = reduce(a, q);
      b = reduce(b, q);
      return (a >= b) ? a - b : a + (q - b);
   endfunction

   function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                               longint unsigned q);
      return reduce(reduce(a, q) * reduce(b, q), q);
   endfunction

   function automatic trio_type mixed_radix_digits(trio_type res);
      trio_type        dig;
      longint unsigned q;
      longint unsigned v;
      longint unsigned inv;
      for (int k = 0; k < 3; k++) begin
         q = modulus[k];
         v = reduce(res[k], q);
         for (int j = 0; j < k; j++) begin
            inv = (k == 1) ? inverse[0] : ((j == 0) ? inverse[1] : inverse[2]);
            v = mul_mod(sub_mod(v, dig[j], q), inv, q);
         end
         dig[k] = word_type'(v);
      end
      return dig;
   endfunction

   function automatic compare_result_type predict_compare(trio_type a, trio_type b);
      compare_result_type r;
      r.invalid = 1'b0;
      r.less    = 1'b0;
      for (int k = 0; k < 3; k++) begin
         r.a_dig[k] = '0;
         r.b_dig[k] = '0;
         if (a[k] >= modulus[k] || b[k] >= modulus[k]) r.invalid = 1'b1;
      end
      if (!r.invalid) begin
         r.a_dig = mixed_radix_digits(a);
         r.b_dig = mixed_radix_digits(b);
         for (int k = 2; k >= 0; k--) begin
            if (r.a_dig[k] < r.b_dig[k]) begin
               r.less = 1'b1;
               break;
            end
            if (r.b_dig[k] < r.a_dig[k]) break;
         end
      end
      return r;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic queue_expected(compare_result_type r);
      pending_results.insert(pending_results.size(), r);
   endtask

   always @(posedge clock) begin
      compare_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = pending_results.pop_front();
            for (int k = 0; k < 3; k++) begin
               if (rsp_tdata[k*MB +: MB] != want.a_dig[k])
                  report_mismatch($sformatf("a_digit_%0d", k), rsp_tdata[k*MB +: MB],
                                  want.a_dig[k]);
               if (rsp_tdata[(3+k)*MB +: MB] != want.b_dig[k])
                  report_mismatch($sformatf("b_digit_%0d", k), rsp_tdata[(3+k)*MB +: MB],
                                  want.b_dig[k]);
            end
            if (rsp_tdata[6*MB] != want.less)
               report_mismatch("a_less_b", rsp_tdata[6*MB], want.less);
            if (rsp_tuser != want.invalid)
               report_mismatch("input_invalid", rsp_tuser, want.invalid);
         end
      end
   end

   // receiver: random ready pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         hold_cycles  <= 400;
         rsp_tready   <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(3, 0);
            mode_left  = $urandom_range(40, 5);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= ($urandom_range(1, 0) == 1);
            end
            2: begin
               rsp_tready <= ($urandom_range(3, 0) != 0);
            end
            default: begin
               rsp_tready <= ($urandom_range(3, 0) == 0);
            end
         endcase
      end
   end

   // ---------------- stimulus helpers ----------------
   task automatic send_pair(trio_type a, trio_type b);
      if (burst_left == 0) begin
         if (sender_gaps) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - 6*MB){1'b0}}, b[2], b[1], b[0], a[2], a[1], a[0]};
      do @(posedge clock); while (!req_tready);
      queue_expected(predict_compare(a, b));
      burst_left--;
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, longint unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= word_type'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (index < 3) modulus[index] = value & 32'h7fff_ffff;
      else inverse[index - 3] = value & 32'h7fff_ffff;
   endtask

   task automatic load_base(longint unsigned m0, longint unsigned m1, longint unsigned m2,
                            longint unsigned i01, longint unsigned i02, longint unsigned i12);
      drain_block();
      write_register(rmc_pkg::CSR_MODULUS_0, m0);
      write_register(rmc_pkg::CSR_MODULUS_1, m1);
      write_register(rmc_pkg::CSR_MODULUS_2, m2);
      write_register(rmc_pkg::CSR_INVERSE_01, i01);
      write_register(rmc_pkg::CSR_INVERSE_02, i02);
      write_register(rmc_pkg::CSR_INVERSE_12, i12);
   endtask

   function automatic word_type random_residue(longint unsigned q);
      int pick;
      pick = $urandom_range(19, 0);
      if (q == 0 || pick == 0) return word_type'($urandom);
      if (pick == 1) return word_type'(q);
      if (pick == 2) return word_type'(q - 1);
      return word_type'($urandom_range(32'(q - 1), 0));
   endfunction

   task automatic send_random_pairs(int count);
      trio_type a;
      trio_type b;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 3; k++) a[k] = random_residue(modulus[k]);
         b = a;
         // some pairs differ in a single residue, the rest are drawn fully at random
         case ($urandom_range(2, 0))
            0: begin
               b[$urandom_range(2, 0)] = random_residue(modulus[$urandom_range(2, 0)]);
            end
            default: begin
               for (int k = 0; k < 3; k++) b[k] = random_residue(modulus[k]);
            end
         endcase
         send_pair(a, b);
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_reset_base();
      trio_type a;
      trio_type b;
      a = '{0, 0, 0};  b = '{0, 0, 0};  send_pair(a, b);
      a = '{2, 4, 6};  b = '{2, 4, 6};  send_pair(a, b);
      a = '{0, 0, 0};  b = '{2, 4, 6};  send_pair(a, b);
      a = '{2, 4, 6};  b = '{0, 0, 0};  send_pair(a, b);
      a = '{1, 0, 0};  b = '{0, 1, 0};  send_pair(a, b);
      a = '{0, 1, 2};  b = '{0, 1, 3};  send_pair(a, b);
      a = '{3, 0, 0};  b = '{0, 0, 0};  send_pair(a, b);
      a = '{0, 5, 0};  b = '{0, 0, 0};  send_pair(a, b);
      a = '{0, 0, 0};  b = '{0, 0, 7};  send_pair(a, b);
      a = '{'1, '1, '1}; b = '{'1, '1, '1}; send_pair(a, b);
      send_random_pairs(40);
   endtask

   task automatic test_widest_base();
      trio_type a;
      trio_type b;
      // largest moduli, inverses 01 and 02 left as all ones so they get reduced, inverse 12 zero
      load_base(32'h7fff_fffd, 32'h7fff_fffe, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 0);
      a = '{32'h7fff_fffc, 32'h7fff_fffd, 32'h7fff_fffe};
      b = '{0, 0, 0};
      send_pair(a, b);
      send_pair(b, a);
      a = '{32'h5555_5555, 32'h2aaa_aaaa, 32'h5555_5555};
      b = '{32'h2aaa_aaaa, 32'h5555_5555, 32'h2aaa_aaaa};
      send_pair(a, b);
      a = '{32'h7fff_fffd, 0, 0};
      send_pair(a, b);
      send_random_pairs(40);
   endtask

   task automatic test_degenerate_moduli();
      trio_type a;
      trio_type b;
      load_base(0, 5, 7, 2, 5, 3);
      a = '{0, 0, 0}; b = '{0, 1, 2};
      send_pair(a, b);
      send_random_pairs(10);
      load_base(1, 1, 9, 7, 1000, 4);
      a = '{0, 0, 8}; b = '{0, 0, 3};
      send_pair(a, b);
      send_pair(b, a);
      send_random_pairs(20);
   endtask

   task automatic test_random_bases();
      for (int phase = 0; phase < 4; phase++) begin
         if (phase[0])
            load_base($urandom_range(32'h7fff_ffff, 32'h4000_0000),
                      $urandom_range(32'h7fff_ffff, 32'h4000_0000),
                      $urandom_range(32'h7fff_ffff, 32'h4000_0000),
                      $urandom, $urandom, $urandom);
         else
            load_base($urandom_range(20, 2), $urandom_range(40, 2), $urandom_range(60, 2),
                      $urandom_range(60, 0), $urandom_range(60, 0), $urandom_range(60, 0));
         sender_gaps = phase != 2;
         send_random_pairs(25);
      end
      sender_gaps = 1'b1;
   endtask

   task automatic test_backpressure();
      load_base(3, 5, 7, 2, 5, 3);
      sender_gaps  = 1'b0;
      hold_request <= 1'b1;
      send_random_pairs(200);
      sender_gaps = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_index    = rmc_pkg::CSR_MODULUS_0;
      csr_wdata    = '0;
      error_count  = 0;
      burst_left   = 0;
      sender_gaps  = 1'b1;
      hold_request = 1'b0;
      hold_cycles  = 0;
      ready_mode   = 0;
      mode_left    = 0;
      modulus      = '{rmc_pkg::RST_MODULUS_0, rmc_pkg::RST_MODULUS_1,
                       rmc_pkg::RST_MODULUS_2};
      inverse      = '{rmc_pkg::RST_INVERSE_01, rmc_pkg::RST_INVERSE_02,
                       rmc_pkg::RST_INVERSE_12};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_base();
      test_widest_base();
      test_degenerate_moduli();
      test_random_bases();
      test_backpressure();
      drain_block();

      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
